>>> hdl/local_history_branch_predictor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the local history branch predictor
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef LOCAL_HISTORY_BRANCH_PREDICTOR_ASSERT_SVH
`define LOCAL_HISTORY_BRANCH_PREDICTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LHBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lhbp_pkg.sv
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared types and constants of the local history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

    localparam int POS_W       = 12;   // branch position width
    localparam int CFG_W       = 5;    // entry count register width
    localparam int REM_W       = 5;    // remainder width, below the divisor
    localparam int OUT_IDX_W   = 4;    // reported entry index width
    localparam int HIST_W      = 2;
    localparam int CTRS_W      = 8;
    localparam int MISS_W      = 16;
    localparam int ENTRY_RESET = 16;   // entry count after reset

    // The remainder unit retires MOD_STEPS position bits per cycle.
    localparam int MOD_STEPS   = 6;
    localparam int MOD_PASSES  = POS_W / MOD_STEPS;

    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 40;

    // Two-bit saturating counter codes.
    localparam logic [1:0] CTR_SN = 2'd0;
    localparam logic [1:0] CTR_WN = 2'd1;
    localparam logic [1:0] CTR_WT = 2'd2;
    localparam logic [1:0] CTR_ST = 2'd3;

    // One predictor entry as held in the table memory.
    typedef struct packed {
        logic [MISS_W-1:0] misses;
        logic [CTRS_W-1:0] ctrs;   // counter k in bits 2k+1..2k
        logic [HIST_W-1:0] hist;   // bit1 older, bit0 newest
    } entry_t;

    // Status of the remainder unit.
    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } mod_res_t;

endpackage

>>> hdl/local_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Two-level local branch predictor with a 2-bit history per entry.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  --------  ---------  ------------------------------------------------------
//  s_        in         branch_position[11:0], actual_taken
//  m_        out        entry_index, history_before, counter_zero..three,
//                       predicted_taken, outcome_echo, mispredicted, miss_total
//  cfg_      in         entries_in_use[4:0]
//
//  Each branch request passes through the accept, two passes of the
//  remainder unit (six position bits each) that end with the table read, and
//  a read-modify-write step that also loads the result register.
//  A new request is taken as soon as the write-back is done, even while the
//  previous result still waits on m_tready; a result only stalls the update
//  cycle when the result register is still full.
//  After reset the table is cleared one entry per cycle, all MAX_ENTRIES entries,
//  while s_tready stays low; configuration requests are taken at any time.
//
module local_history_branch_predictor #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] branch_position, [12] actual_taken, [15:13] zero
    input  logic [lhbp_pkg::S_DATA_W-1:0]   s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] entry_index, [5:4] history_before, [7:6] counter_zero,
    // [9:8] counter_one, [11:10] counter_two, [13:12] counter_three,
    // [14] predicted_taken, [15] outcome_echo, [16] mispredicted,
    // [32:17] miss_total, [39:33] zero
    output logic [lhbp_pkg::M_DATA_W-1:0]   m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lhbp_pkg::CFG_W-1:0]      cfg_data
);
    import lhbp_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CFG_MAX = (2 ** CFG_W) - 1;
    // The entry count register can never address past its own range.
    localparam logic [CFG_W-1:0] EFF_CAP =
        (MAX_ENTRIES > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_ENTRIES);
    localparam logic [CFG_W-1:0] EFF_RESET =
        (ENTRY_RESET > EFF_CAP) ? EFF_CAP : CFG_W'(ENTRY_RESET);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [1:0] {
        CLEAR,
        IDLE,
        DIVIDE,
        UPDATE
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       clr_addr_reg;
    logic [CFG_W-1:0]       eff_reg;
    logic                   taken_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [OUT_IDX_W-1:0]   idx_out_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg;

    logic                   accept;
    logic                   out_free;
    mod_res_t               mod_res;
    logic [IDX_W+REM_W-1:0] rem_wide;
    logic [IDX_W-1:0]       rd_addr;
    entry_t                 rd_entry;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    entry_t                 wr_entry;
    entry_t                 upd_entry;
    logic [CFG_W-1:0]       cfg_eff;

    logic [1:0]             sel;
    logic [1:0]             sel_new;
    logic                   pred;
    logic                   miss;
    logic [MISS_W-1:0]      total;
    logic [CTRS_W-1:0]      ctrs_new;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // A zero entry count behaves as one entry; larger counts saturate.
    always_comb begin
        if (cfg_data == '0) begin
            cfg_eff = CFG_W'(1);
        end else if (cfg_data > EFF_CAP) begin
            cfg_eff = EFF_CAP;
        end else begin
            cfg_eff = cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Entry index: position modulo the entry count. The table read is
    // issued in the same cycle as the last remainder pass.
    // ------------------------------------------------------------------
    lhbp_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .pos     (s_tdata[POS_W-1:0]),
        .divisor (eff_reg),
        .res     (mod_res)
    );

    assign rem_wide = {{IDX_W{1'b0}}, mod_res.rem};
    assign rd_addr  = rem_wide[IDX_W-1:0];

    lhbp_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (mod_res.done),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // ------------------------------------------------------------------
    // Predict and update. Requests are handled one at a time and the
    // write-back lands before the next read, so the same entry can never
    // be read stale.
    // ------------------------------------------------------------------
    always_comb begin
        sel  = rd_entry.ctrs[{rd_entry.hist, 1'b0} +: 2];
        pred = (sel >= CTR_WT);
        miss = (pred != taken_reg);

        if (miss && (rd_entry.misses != '1)) begin
            total = rd_entry.misses + MISS_W'(1);
        end else begin
            total = rd_entry.misses;
        end

        if (taken_reg) begin
            sel_new = (sel == CTR_ST) ? sel : sel + 2'd1;
        end else begin
            sel_new = (sel == CTR_SN) ? sel : sel - 2'd1;
        end

        ctrs_new = rd_entry.ctrs;
        ctrs_new[{rd_entry.hist, 1'b0} +: 2] = sel_new;

        upd_entry.misses = total;
        upd_entry.ctrs   = ctrs_new;
        upd_entry.hist   = {rd_entry.hist[0], taken_reg};
    end

    // The clearing pass and the update share the single write port.
    always_comb begin
        if (state_reg == CLEAR) begin
            wr_en    = 1'b1;
            wr_addr  = clr_addr_reg;
            wr_entry = '0;
        end else begin
            wr_en    = (state_reg == UPDATE) && out_free;
            wr_addr  = idx_reg;
            wr_entry = upd_entry;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, configuration and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CLEAR;
            clr_addr_reg <= '0;
            eff_reg      <= EFF_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                eff_reg <= cfg_eff;
            end

            // A new result takes the register over a drained one.
            if ((state_reg == UPDATE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_ADDR) begin
                        state_reg <= IDLE;
                    end
                end
                IDLE: begin
                    if (accept) begin
                        taken_reg <= s_tdata[POS_W];
                        state_reg <= DIVIDE;
                    end
                end
                DIVIDE: begin
                    if (mod_res.done) begin
                        idx_reg     <= rd_addr;
                        idx_out_reg <= mod_res.rem[OUT_IDX_W-1:0];
                        state_reg   <= UPDATE;
                    end
                end
                UPDATE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {7'd0, total, miss, taken_reg, pred,
                                         rd_entry.ctrs, rd_entry.hist, idx_out_reg};
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/lhbp_mod.sv
// ----------------------------------------------------------------------------
// lhbp_mod
// Iterative remainder unit: branch position modulo the entry count.
// ----------------------------------------------------------------------------
module lhbp_mod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lhbp_pkg::POS_W-1:0]  pos,
    input  logic [lhbp_pkg::REM_W-1:0]  divisor,
    output lhbp_pkg::mod_res_t          res
);
    import lhbp_pkg::*;

    localparam int PASS_W = (MOD_PASSES > 1) ? $clog2(MOD_PASSES) : 1;
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(MOD_PASSES - 1);

    logic              busy_reg;
    logic [PASS_W-1:0] pass_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [POS_W-1:0]  shift_reg;
    logic [REM_W-1:0]  div_reg;
    logic [REM_W-1:0]  rem_next;

    // Restoring remainder, several bits per cycle. The partial remainder
    // stays below the divisor, so one compare and subtract per bit is enough.
    always_comb begin
        logic [REM_W:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < MOD_STEPS; i++) begin
            trial = {rem_next, shift_reg[POS_W-1-i]};
            if (trial >= {1'b0, div_reg}) begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[REM_W-1:0];
        end
    end

    assign res.done = busy_reg && (pass_reg == LAST_PASS);
    assign res.rem  = rem_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pass_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            pass_reg <= '0;
        end else if (res.done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            pass_reg <= pass_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            shift_reg <= pos;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << MOD_STEPS;
        end
    end

endmodule

>>> hdl/lhbp_table.sv
// ----------------------------------------------------------------------------
// lhbp_table
// Predictor entry memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lhbp_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  lhbp_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output lhbp_pkg::entry_t    rd_data
);
    import lhbp_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/lhbp_checker.sv
// ----------------------------------------------------------------------------
// lhbp_checker
// Port-level checks of the local history branch predictor, bound to the top.
// ----------------------------------------------------------------------------
`include "local_history_branch_predictor_assert.svh"

module lhbp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [15:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    // A stalled result holds its value.
    `LHBP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Requests are handled one at a time.
    `LHBP_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while one is in flight")

    // The miss flag is the prediction compared with the outcome.
    `LHBP_ASSERT_NOW(a_miss_flag, aclk, aresetn, m_tvalid, m_tdata[16] == (m_tdata[14] ^ m_tdata[15]), "miss flag inconsistent")

    // The prediction is the upper bit of the counter that the history selects.
    `LHBP_ASSERT_NOW(a_pred_sel, aclk, aresetn, m_tvalid, m_tdata[14] == ((m_tdata[5:4] == 2'd0) ? m_tdata[7] : (m_tdata[5:4] == 2'd1) ? m_tdata[9] : (m_tdata[5:4] == 2'd2) ? m_tdata[11] : m_tdata[13]), "prediction does not match selected counter")

    // A miss leaves a nonzero miss count behind.
    `LHBP_ASSERT_NOW(a_miss_count, aclk, aresetn, m_tvalid && m_tdata[16], m_tdata[32:17] != 16'd0, "miss count zero after a miss")

endmodule

bind local_history_branch_predictor lhbp_checker u_lhbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
